FILE: rtl/core/mme_pkg.sv
// Shared types and constants of the matrix multiply engine.
// Holds the input and result word layouts, mode and register codes.
// No dependencies.
package mme_pkg;

  localparam int MaxDim    = 8;
  localparam int ElemWidth = 16;
  localparam int AccWidth  = 40;
  localparam int CfgWidth  = 4;
  localparam int IdxWidth  = 3;
  localparam int CfgIdxW   = 2;

  typedef enum logic [1:0] {
    ModeLoadA   = 2'd0,
    ModeLoadB   = 2'd1,
    ModeCompute = 2'd2
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRowsA    = 2'd0,
    CfgInnerDim = 2'd1,
    CfgColsB    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    mode_e                        mode;
    logic [IdxWidth-1:0]          elem_row;
    logic [IdxWidth-1:0]          elem_col;
    logic signed [ElemWidth-1:0]  elem_value;
  } mme_in_t;

  typedef struct packed {
    logic [IdxWidth-1:0]          out_row;
    logic [IdxWidth-1:0]          out_col;
    logic signed [AccWidth-1:0]   product_value;
    logic                         last;
  } mme_out_t;

endpackage

FILE: rtl/core/matrix_multiply_engine.sv
// Matrix multiply engine: stores A and B in two synchronous RAMs and emits A*B.
// Loads are accepted only while the sequencer idles. Each result sums N products,
// read through the single read port of each RAM into the product and accumulate
// registers; a run forms M*P*N products and stalls while an output word is held.
// Reset: dimensions return to 8, the sequencer idles, the RAMs keep their contents
// (undefined until written, no clearing pass). Depends on mme_pkg.
module matrix_multiply_engine import mme_pkg::*; #(
  parameter int MAX_DIM = MaxDim
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  mme_in_t              in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output mme_out_t             out_word_o,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgWidth-1:0]  cfg_data_i
);

  localparam int Depth = MAX_DIM * MAX_DIM;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StRun  = 2'b10
  } seq_state_e;

  typedef struct packed {
    logic                valid;
    logic                first;
    logic                last_k;
    logic                is_end;
    logic [IdxWidth-1:0] row;
    logic [IdxWidth-1:0] col;
  } tag_t;

  function automatic logic [CfgWidth-1:0] clamp_dim(input logic [CfgWidth-1:0] d);
    logic [CfgWidth-1:0] res;
    res = d;
    if (d == '0) begin
      res = CfgWidth'(1);
    end else if (int'(d) > MAX_DIM) begin
      res = CfgWidth'(MAX_DIM);
    end
    return res;
  endfunction

  // configuration
  logic [CfgWidth-1:0] rows_q, inner_q, cols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= CfgWidth'(8);
      inner_q <= CfgWidth'(8);
      cols_q  <= CfgWidth'(8);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgRowsA:    rows_q  <= cfg_data_i;
        CfgInnerDim: inner_q <= cfg_data_i;
        CfgColsB:    cols_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer
  seq_state_e          seq_q, seq_d;
  logic [CfgWidth-1:0] m_q, m_d, n_q, n_d, p_q, p_d;
  logic [CfgWidth-1:0] r_q, r_d, c_q, c_d, k_q, k_d;
  logic                adv, in_fire, issue;
  logic                k_last, c_last, r_last;

  logic                out_valid_q;
  mme_out_t            out_q;

  // the whole pipeline freezes while a finished word waits
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = (seq_q == StRun);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign issue      = (seq_q == StRun) && adv;

  assign k_last = (k_q == n_q - CfgWidth'(1));
  assign c_last = (c_q == p_q - CfgWidth'(1));
  assign r_last = (r_q == m_q - CfgWidth'(1));

  always_comb begin
    seq_d = seq_q;
    m_d   = m_q;
    n_d   = n_q;
    p_d   = p_q;
    r_d   = r_q;
    c_d   = c_q;
    k_d   = k_q;
    unique case (seq_q)
      StIdle: begin
        if (in_fire && in_word_i.mode == ModeCompute) begin
          seq_d = StRun;
          m_d   = clamp_dim(rows_q);
          n_d   = clamp_dim(inner_q);
          p_d   = clamp_dim(cols_q);
          r_d   = '0;
          c_d   = '0;
          k_d   = '0;
        end
      end
      StRun: begin
        if (adv) begin
          if (!k_last) begin
            k_d = k_q + CfgWidth'(1);
          end else begin
            k_d = '0;
            if (c_last) begin
              c_d = '0;
              if (r_last) begin
                seq_d = StIdle;
              end else begin
                r_d = r_q + CfgWidth'(1);
              end
            end else begin
              c_d = c_q + CfgWidth'(1);
            end
          end
        end
      end
      default: seq_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= StIdle;
      m_q   <= '0;
      n_q   <= '0;
      p_q   <= '0;
      r_q   <= '0;
      c_q   <= '0;
      k_q   <= '0;
    end else begin
      seq_q <= seq_d;
      m_q   <= m_d;
      n_q   <= n_d;
      p_q   <= p_d;
      r_q   <= r_d;
      c_q   <= c_d;
      k_q   <= k_d;
    end
  end

  // element stores
  logic [AddrW-1:0]            wr_addr, rd_addr_a, rd_addr_b;
  logic                        wr_ok, wr_a, wr_b;
  logic signed [ElemWidth-1:0] store_a_q [Depth];
  logic signed [ElemWidth-1:0] store_b_q [Depth];
  logic signed [ElemWidth-1:0] rd_a_q, rd_b_q;

  assign wr_ok   = (int'(in_word_i.elem_row) < MAX_DIM) &&
                   (int'(in_word_i.elem_col) < MAX_DIM);
  assign wr_addr = AddrW'(int'(in_word_i.elem_row) * MAX_DIM + int'(in_word_i.elem_col));
  assign wr_a    = in_fire && wr_ok && (in_word_i.mode == ModeLoadA);
  assign wr_b    = in_fire && wr_ok && (in_word_i.mode == ModeLoadB);

  assign rd_addr_a = AddrW'(int'(r_q) * MAX_DIM + int'(k_q));
  assign rd_addr_b = AddrW'(int'(k_q) * MAX_DIM + int'(c_q));

  // loads and reads never share a cycle: loads wait while the sequencer runs
  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      store_a_q[wr_addr] <= in_word_i.elem_value;
    end
    if (issue) begin
      rd_a_q <= store_a_q[rd_addr_a];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_b) begin
      store_b_q[wr_addr] <= in_word_i.elem_value;
    end
    if (issue) begin
      rd_b_q <= store_b_q[rd_addr_b];
    end
  end

  // pipeline tags and datapath
  tag_t                          s1_q, s2_q;
  logic signed [2*ElemWidth-1:0] prod_q;
  logic signed [AccWidth-1:0]    acc_q, acc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
    end else if (adv) begin
      s1_q.valid  <= issue;
      s1_q.first  <= (k_q == '0);
      s1_q.last_k <= k_last;
      s1_q.is_end <= k_last && c_last && r_last;
      s1_q.row    <= IdxWidth'(r_q);
      s1_q.col    <= IdxWidth'(c_q);
      s2_q        <= s1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_q <= rd_a_q * rd_b_q;
    end
  end

  // restart the sum on the first product of each result
  assign acc_d = (s2_q.first ? AccWidth'(0) : acc_q) + AccWidth'(prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      if (s2_q.valid) begin
        acc_q <= acc_d;
      end
      out_valid_q <= s2_q.valid && s2_q.last_k;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s2_q.valid && s2_q.last_k) begin
      out_q.out_row       <= s2_q.row;
      out_q.out_col       <= s2_q.col;
      out_q.product_value <= acc_d;
      out_q.last          <= s2_q.is_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // checks
  a_run_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_q == StRun |-> n_q != '0 && k_q < n_q && c_q < p_q && r_q < m_q)
    else $error("sequencer index beyond latched dimension");

  a_compute_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_word_i.mode == ModeCompute |=> seq_q == StRun)
    else $error("compute word did not start the sequencer");

  a_end_is_last_k: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_q.valid && s1_q.is_end |-> s1_q.last_k)
    else $error("run end tagged on a partial sum");

  a_no_load_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_a || wr_b) |-> !issue)
    else $error("store written while a read is issued");

  a_freeze_holds_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> $stable(acc_q) && $stable(s2_q))
    else $error("pipeline advanced while the result word was held");

endmodule
